[hdl/lis_pkg.sv]
package lis_pkg;

  localparam int MAX_LEN = 1024;
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 11;
  localparam int ADDR_W  = $clog2(MAX_LEN);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LAST = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             done_res;
    logic             overflow;
  } result_t;

  function automatic logic [VAL_W-1:0] order_key(input logic signed [VAL_W-1:0] v);
    order_key = {~v[VAL_W-1], v[VAL_W-2:0]};
  endfunction

endpackage

[hdl/lis_if.sv]
interface lis_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lis_pkg::VAL_W-1:0] value;
  logic                             first;
  logic                             last;

  modport source (output valid, output value, output first, output last, input ready);
  modport sink (input valid, input value, input first, input last, output ready);
endinterface

interface lis_out_if;
  logic                      valid;
  logic                      ready;
  logic [lis_pkg::LEN_W-1:0] length;
  logic                      done_res;
  logic                      overflow;

  modport source (output valid, output length, output done_res, output overflow,
                  input ready);
  modport sink (input valid, input length, input done_res, input overflow,
                output ready);
endinterface

[hdl/lis_tails_ram.sv]
module lis_tails_ram (
  input  logic                         clk,
  input  lis_pkg::ram_req_t            req,
  output logic [lis_pkg::VAL_W-1:0]    rd_data
);

  logic [lis_pkg::VAL_W-1:0] mem [lis_pkg::MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[hdl/lis_ctrl.sv]
module lis_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  lis_in_if.sink                    din,
  output lis_pkg::ram_req_t         ram_req,
  input  logic [lis_pkg::VAL_W-1:0] rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output lis_pkg::result_t          res
);

  logic [1:0]                  state, state_next;
  logic [lis_pkg::LEN_W-1:0]   cnt, cnt_next;
  logic                        ovf, ovf_next;
  logic [lis_pkg::ADDR_W-1:0]  lo, lo_next;
  logic [lis_pkg::ADDR_W-1:0]  hi, hi_next;
  logic [lis_pkg::ADDR_W-1:0]  mid, mid_next;
  logic [lis_pkg::VAL_W-1:0]   key;
  logic                        last_r;

  logic                        accept;
  logic                        finish;
  logic [lis_pkg::VAL_W-1:0]   key_in;
  logic [lis_pkg::LEN_W-1:0]   cnt_in;
  logic [lis_pkg::LEN_W-1:0]   cnt_dec;

  assign din.ready = (state == lis_pkg::ST_IDLE);
  assign accept    = din.valid && din.ready;
  assign key_in    = lis_pkg::order_key(din.value);
  assign cnt_in    = din.first ? '0 : cnt;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ovf_next   = ovf;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    ram_req    = '0;
    finish     = 1'b0;
    cnt_dec    = '0;
    case (state)
      lis_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_next = cnt_in;
          ovf_next = din.first ? 1'b0 : ovf;
          if (cnt_in == '0) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = '0;
            ram_req.wr_data = key_in;
            cnt_next        = lis_pkg::LEN_W'(1);
            finish          = 1'b1;
          end else begin
            cnt_dec         = cnt_in - lis_pkg::LEN_W'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = cnt_dec[lis_pkg::ADDR_W-1:0];
            state_next      = lis_pkg::ST_LAST;
          end
        end
      end
      lis_pkg::ST_LAST: begin
        if (key > rd_data) begin
          if (cnt == lis_pkg::LEN_W'(lis_pkg::MAX_LEN)) begin
            ovf_next = 1'b1;
          end else begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt[lis_pkg::ADDR_W-1:0];
            ram_req.wr_data = key;
            cnt_next        = cnt + lis_pkg::LEN_W'(1);
          end
          finish = 1'b1;
        end else begin
          cnt_dec = cnt - lis_pkg::LEN_W'(1);
          lo_next = '0;
          hi_next = cnt_dec[lis_pkg::ADDR_W-1:0];
          if (hi_next != '0) begin
            mid_next        = hi_next >> 1;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = mid_next;
            state_next      = lis_pkg::ST_SRCH;
          end else begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = '0;
            ram_req.wr_data = key;
            finish          = 1'b1;
          end
        end
      end
      lis_pkg::ST_SRCH: begin
        if (rd_data < key) begin
          lo_next = mid + lis_pkg::ADDR_W'(1);
        end else begin
          hi_next = mid;
        end
        if (lo_next < hi_next) begin
          mid_next        = lo_next + ((hi_next - lo_next) >> 1);
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = mid_next;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = lo_next;
          ram_req.wr_data = key;
          finish          = 1'b1;
        end
      end
      lis_pkg::ST_HOLD: begin
        if (res_ready) begin
          state_next = lis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lis_pkg::ST_IDLE;
      end
    endcase
    if (finish) begin
      state_next = res_ready ? lis_pkg::ST_IDLE : lis_pkg::ST_HOLD;
    end
  end

  assign res_valid    = finish || (state == lis_pkg::ST_HOLD);
  assign res.length   = cnt_next;
  assign res.overflow = ovf_next;
  assign res.done_res = (state == lis_pkg::ST_IDLE) ? din.last : last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lis_pkg::ST_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (accept) begin
      key    <= key_in;
      last_r <= din.last;
    end
  end

endmodule

[hdl/lis_length_patience_tails.sv]
// Longest strictly increasing subsequence length over a stream of signed 32-bit
// values, kept in patience-sorting form: a 1024-entry tails RAM holds the
// smallest end value of each increasing run length, and every item returns the
// current length, the last flag of that item and a sticky overflow flag (set
// when an append finds the RAM full; cleared by an item with first set). One
// item is in flight at a time. An item at length zero is written straight into
// the tails RAM; else the last tail is read and compared, and the item appends
// or, at length one, replaces that tail; else a binary search finds the tail
// it replaces, making one probe per cycle through the single read port of the
// tails RAM. A finished result sits in the output register, so the next item
// is taken while the result waits; if the register is still full when an item
// finishes, the block holds that result and stops taking items.
module lis_length_patience_tails (
  input  logic       clk,
  input  logic       rst,
  lis_in_if.sink     din,
  lis_out_if.source  dout
);

  lis_pkg::ram_req_t         ram_req;
  logic [lis_pkg::VAL_W-1:0] rd_data;
  lis_pkg::result_t          res;
  logic                      res_valid;
  logic                      res_ready;

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lis_tails_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign res_ready = !dout.valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      dout.length   <= res.length;
      dout.done_res <= res.done_res;
      dout.overflow <= res.overflow;
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.length <= lis_pkg::LEN_W'(lis_pkg::MAX_LEN))
    else $error("length above store depth");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.length != '0)
    else $error("zero length after an item");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.overflow) |-> dout.length == lis_pkg::LEN_W'(lis_pkg::MAX_LEN))
    else $error("overflow with store not full");

  a_held_result_stalls: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> !din.ready)
    else $error("item taken while a result is held");
`endif

endmodule
